@@ rtl/dipsc_pkg.sv @@
// Shared widths, register indexes and reset values for the dual incremental PI
// speed controller. No dependencies.
`default_nettype none

package dipsc_pkg;

    localparam int SAMPLE_WIDTH       = 16;
    localparam int GAIN_FRACTION_BITS = 14;
    localparam int GAIN_WIDTH         = 16;

    localparam int ERR_WIDTH   = SAMPLE_WIDTH + 1;
    localparam int LIMIT_WIDTH = SAMPLE_WIDTH - 1;
    localparam int PROD_WIDTH  = ERR_WIDTH + GAIN_WIDTH;
    localparam int FB_WIDTH    = SAMPLE_WIDTH + GAIN_FRACTION_BITS;
    localparam int ACC_WIDTH   = ((PROD_WIDTH > FB_WIDTH) ? PROD_WIDTH : FB_WIDTH) + 2;
    localparam int SHIFT_WIDTH = ACC_WIDTH - GAIN_FRACTION_BITS;

    localparam int CFG_INDEX_WIDTH = 3;
    localparam int CFG_DATA_WIDTH  = (GAIN_WIDTH > SAMPLE_WIDTH) ? GAIN_WIDTH : SAMPLE_WIDTH;

    localparam int IN_FIELDS_WIDTH  = 1 + 2 * SAMPLE_WIDTH;
    localparam int IN_DATA_WIDTH    = ((IN_FIELDS_WIDTH + 7) / 8) * 8;
    localparam int OUT_FIELDS_WIDTH = 2 * SAMPLE_WIDTH + 2 * ERR_WIDTH;
    localparam int OUT_DATA_WIDTH   = ((OUT_FIELDS_WIDTH + 7) / 8) * 8;

    localparam logic [CFG_INDEX_WIDTH-1:0] REG_REFERENCE_SPEED = 3'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_VOLTAGE_LIMIT   = 3'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_GAIN_NOW_A      = 3'd2;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_GAIN_PREV_A     = 3'd3;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_GAIN_NOW_B      = 3'd4;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_GAIN_PREV_B     = 3'd5;

    localparam logic signed [SAMPLE_WIDTH-1:0] RESET_REFERENCE_SPEED = 16'sd2560;
    localparam logic        [LIMIT_WIDTH-1:0]  RESET_VOLTAGE_LIMIT   = 15'd3072;
    localparam logic signed [GAIN_WIDTH-1:0]   RESET_GAIN_NOW_A      = 16'sd10476;
    localparam logic signed [GAIN_WIDTH-1:0]   RESET_GAIN_PREV_A     = -16'sd9667;
    localparam logic signed [GAIN_WIDTH-1:0]   RESET_GAIN_NOW_B      = 16'sd10210;
    localparam logic signed [GAIN_WIDTH-1:0]   RESET_GAIN_PREV_B     = -16'sd9421;

endpackage

`default_nettype wire

@@ rtl/dual_incremental_pi_speed_control.sv @@
// Top level of the dual incremental PI speed controller: input stage, per-wheel
// velocity-form PI update with clamp, result register. Depends on dipsc_pkg.
`default_nettype none

// Takes one beat per clock while m_tready is high and returns one result beat per
// input beat via the input register and then the result register. Each wheel computes
// e = reference - speed and u = floor((g_now*e + g_prev*e_prev + (u_prev << 14)) / 2^14),
// clamped to +/- voltage_limit, combinationally between the input register and
// the result register; the stored error and drive feed the next beat. A beat
// with enable low outputs zero drives, still reports the errors, and clears the
// stored state. Write configuration only while no beat is in flight.
module dual_incremental_pi_speed_control
    import dipsc_pkg::*;
(
    input  wire                        aclk,
    input  wire                        aresetn,
    input  wire                        cfg_wr_en,
    input  wire [CFG_INDEX_WIDTH-1:0]  cfg_index,
    input  wire [CFG_DATA_WIDTH-1:0]   cfg_wr_data,
    input  wire                        s_tvalid,
    output logic                       s_tready,
    // enable, speed_a, speed_b, zero fill
    input  wire [IN_DATA_WIDTH-1:0]    s_tdata,
    output logic                       m_tvalid,
    input  wire                        m_tready,
    // drive_a, drive_b, error_a, error_b, zero fill
    output logic [OUT_DATA_WIDTH-1:0]  m_tdata
);

    logic signed [SAMPLE_WIDTH-1:0] reference_speed_reg;
    logic        [LIMIT_WIDTH-1:0]  voltage_limit_reg;
    logic signed [GAIN_WIDTH-1:0]   gain_now_a_reg, gain_prev_a_reg;
    logic signed [GAIN_WIDTH-1:0]   gain_now_b_reg, gain_prev_b_reg;

    logic signed [ERR_WIDTH-1:0]    last_error_a_reg, last_error_b_reg;
    logic signed [SAMPLE_WIDTH-1:0] last_drive_a_reg, last_drive_b_reg;

    logic                           in_valid_reg;
    logic                           enable_reg;
    logic signed [SAMPLE_WIDTH-1:0] speed_a_reg, speed_b_reg;

    logic                           out_open;
    logic                           advance;
    logic signed [ERR_WIDTH-1:0]    error_a, error_b;
    logic signed [SAMPLE_WIDTH-1:0] drive_a, drive_b;
    logic signed [SAMPLE_WIDTH-1:0] drive_a_next, drive_b_next;
    logic [OUT_FIELDS_WIDTH-1:0]    out_fields;

    function automatic logic signed [SAMPLE_WIDTH-1:0] pi_update(
        input logic signed [ERR_WIDTH-1:0]    e,
        input logic signed [GAIN_WIDTH-1:0]   g_now,
        input logic signed [GAIN_WIDTH-1:0]   g_prev,
        input logic signed [ERR_WIDTH-1:0]    e_prev,
        input logic signed [SAMPLE_WIDTH-1:0] u_prev,
        input logic        [LIMIT_WIDTH-1:0]  limit
    );
        logic signed [PROD_WIDTH-1:0]  p_now;
        logic signed [PROD_WIDTH-1:0]  p_prev;
        logic signed [ACC_WIDTH-1:0]   acc;
        logic signed [SHIFT_WIDTH-1:0] u;
        logic signed [SHIFT_WIDTH-1:0] hi;
        logic signed [SHIFT_WIDTH-1:0] lo;
        p_now  = PROD_WIDTH'(e) * PROD_WIDTH'(g_now);
        p_prev = PROD_WIDTH'(e_prev) * PROD_WIDTH'(g_prev);
        acc    = ACC_WIDTH'(p_now) + ACC_WIDTH'(p_prev)
               + (ACC_WIDTH'(u_prev) <<< GAIN_FRACTION_BITS);
        u      = acc[ACC_WIDTH-1:GAIN_FRACTION_BITS];
        hi     = $signed({{(SHIFT_WIDTH-LIMIT_WIDTH){1'b0}}, limit});
        lo     = -hi;
        if (u > hi) begin
            u = hi;
        end else if (u < lo) begin
            u = lo;
        end
        return u[SAMPLE_WIDTH-1:0];
    endfunction

    assign out_open = !m_tvalid || m_tready;
    assign advance  = in_valid_reg && out_open;
    assign s_tready = !in_valid_reg || out_open;

    assign error_a = ERR_WIDTH'(reference_speed_reg) - ERR_WIDTH'(speed_a_reg);
    assign error_b = ERR_WIDTH'(reference_speed_reg) - ERR_WIDTH'(speed_b_reg);

    assign drive_a_next = pi_update(error_a, gain_now_a_reg, gain_prev_a_reg,
                                    last_error_a_reg, last_drive_a_reg, voltage_limit_reg);
    assign drive_b_next = pi_update(error_b, gain_now_b_reg, gain_prev_b_reg,
                                    last_error_b_reg, last_drive_b_reg, voltage_limit_reg);

    assign drive_a = enable_reg ? drive_a_next : '0;
    assign drive_b = enable_reg ? drive_b_next : '0;

    assign out_fields = {error_b, error_a, drive_b, drive_a};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            reference_speed_reg <= RESET_REFERENCE_SPEED;
            voltage_limit_reg   <= RESET_VOLTAGE_LIMIT;
            gain_now_a_reg      <= RESET_GAIN_NOW_A;
            gain_prev_a_reg     <= RESET_GAIN_PREV_A;
            gain_now_b_reg      <= RESET_GAIN_NOW_B;
            gain_prev_b_reg     <= RESET_GAIN_PREV_B;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_REFERENCE_SPEED: reference_speed_reg <= cfg_wr_data[SAMPLE_WIDTH-1:0];
                REG_VOLTAGE_LIMIT:   voltage_limit_reg   <= cfg_wr_data[LIMIT_WIDTH-1:0];
                REG_GAIN_NOW_A:      gain_now_a_reg      <= cfg_wr_data[GAIN_WIDTH-1:0];
                REG_GAIN_PREV_A:     gain_prev_a_reg     <= cfg_wr_data[GAIN_WIDTH-1:0];
                REG_GAIN_NOW_B:      gain_now_b_reg      <= cfg_wr_data[GAIN_WIDTH-1:0];
                REG_GAIN_PREV_B:     gain_prev_b_reg     <= cfg_wr_data[GAIN_WIDTH-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            enable_reg  <= s_tdata[0];
            speed_a_reg <= s_tdata[SAMPLE_WIDTH:1];
            speed_b_reg <= s_tdata[2*SAMPLE_WIDTH:SAMPLE_WIDTH+1];
        end
    end

    // hold state on a disabled beat at zero
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_error_a_reg <= '0;
            last_error_b_reg <= '0;
            last_drive_a_reg <= '0;
            last_drive_b_reg <= '0;
        end else if (advance) begin
            last_error_a_reg <= enable_reg ? error_a : '0;
            last_error_b_reg <= enable_reg ? error_b : '0;
            last_drive_a_reg <= drive_a;
            last_drive_b_reg <= drive_b;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid <= 1'b0;
        end else if (out_open) begin
            m_tvalid <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            m_tdata <= OUT_DATA_WIDTH'(out_fields);
        end
    end

endmodule

`default_nettype wire

@@ rtl/dipsc_checker.sv @@
// Port-level checks for the dual incremental PI speed controller, bound to the
// top level. Depends on dipsc_pkg.
`default_nettype none

module dipsc_checker
    import dipsc_pkg::*;
(
    input wire                       aclk,
    input wire                       aresetn,
    input wire                       s_tvalid,
    input wire                       s_tready,
    input wire                       m_tvalid,
    input wire                       m_tready,
    input wire [OUT_DATA_WIDTH-1:0]  m_tdata
);

    localparam logic [SAMPLE_WIDTH-1:0] MOST_NEGATIVE = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat changed while stalled");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    a_ready_when_drained: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tready |-> s_tready)
        else $error("input stalled while result side is taking beats");

    a_drive_clamped: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[SAMPLE_WIDTH-1:0] != MOST_NEGATIVE
                  && m_tdata[2*SAMPLE_WIDTH-1:SAMPLE_WIDTH] != MOST_NEGATIVE)
        else $error("drive outside symmetric clamp");

    a_one_result_per_beat: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tvalid ##1 (!m_tvalid && !s_tvalid) ##1 !s_tvalid |=> !m_tvalid)
        else $error("result beat without an input beat");

endmodule

bind dual_incremental_pi_speed_control dipsc_checker u_dipsc_checker (.*);

`default_nettype wire

@@ tb/tb_top.sv @@
// Self-checking bench for dual_incremental_pi_speed_control: directed and random
// speed beats under random valid/ready idling, predicted per tick and checked
// field by field. Depends on dipsc_pkg and the controller RTL.
`default_nettype none

module tb_top;
    import dipsc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned CYCLE_LIMIT = 200000;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_SPARE_HI = 3'd7;

    localparam logic signed [GAIN_WIDTH-1:0] LOW_GAIN_NOW_A  = 16'sd8040;
    localparam logic signed [GAIN_WIDTH-1:0] LOW_GAIN_PREV_A = -16'sd7972;
    localparam logic signed [GAIN_WIDTH-1:0] LOW_GAIN_NOW_B  = 16'sd7849;
    localparam logic signed [GAIN_WIDTH-1:0] LOW_GAIN_PREV_B = -16'sd7784;

    typedef struct packed {
        logic signed [ERR_WIDTH-1:0]    error_b;
        logic signed [ERR_WIDTH-1:0]    error_a;
        logic signed [SAMPLE_WIDTH-1:0] drive_b;
        logic signed [SAMPLE_WIDTH-1:0] drive_a;
    } tick_result_t;

    class drive_scoreboard;
        logic signed [SAMPLE_WIDTH-1:0] ref_speed;
        logic        [LIMIT_WIDTH-1:0]  volt_limit;
        logic signed [GAIN_WIDTH-1:0]   g_now_a, g_prev_a, g_now_b, g_prev_b;
        logic signed [ERR_WIDTH-1:0]    held_err_a, held_err_b;
        logic signed [SAMPLE_WIDTH-1:0] held_drv_a, held_drv_b;
        tick_result_t                   queued_ticks[$];
        int                             mismatches;

        function new();
            ref_speed  = RESET_REFERENCE_SPEED;
            volt_limit = RESET_VOLTAGE_LIMIT;
            g_now_a    = RESET_GAIN_NOW_A;
            g_prev_a   = RESET_GAIN_PREV_A;
            g_now_b    = RESET_GAIN_NOW_B;
            g_prev_b   = RESET_GAIN_PREV_B;
            held_err_a = '0;
            held_err_b = '0;
            held_drv_a = '0;
            held_drv_b = '0;
            mismatches = 0;
        endfunction

        function void write_reg(logic [CFG_INDEX_WIDTH-1:0] idx,
                                logic [CFG_DATA_WIDTH-1:0] value);
            case (idx)
                REG_REFERENCE_SPEED: ref_speed  = value;
                REG_VOLTAGE_LIMIT:   volt_limit = value[LIMIT_WIDTH-1:0];
                REG_GAIN_NOW_A:      g_now_a    = value;
                REG_GAIN_PREV_A:     g_prev_a   = value;
                REG_GAIN_NOW_B:      g_now_b    = value;
                REG_GAIN_PREV_B:     g_prev_b   = value;
                default: ;
            endcase
        endfunction

        function logic signed [SAMPLE_WIDTH-1:0] wheel_drive(
                longint err, logic signed [GAIN_WIDTH-1:0] gn,
                logic signed [GAIN_WIDTH-1:0] gp, logic signed [ERR_WIDTH-1:0] err_prev,
                logic signed [SAMPLE_WIDTH-1:0] drv_prev);
            longint acc;
            longint u;
            longint lim;
            lim = volt_limit;
            if (lim > (2 ** (SAMPLE_WIDTH - 1)) - 1)
                lim = (2 ** (SAMPLE_WIDTH - 1)) - 1;
            acc = longint'(gn) * err + longint'(gp) * longint'(err_prev)
                + (longint'(drv_prev) <<< GAIN_FRACTION_BITS);
            u = acc >>> GAIN_FRACTION_BITS;
            if (u > lim)
                u = lim;
            if (u < -lim)
                u = -lim;
            return u[SAMPLE_WIDTH-1:0];
        endfunction

        function void take_tick(bit en, logic signed [SAMPLE_WIDTH-1:0] sa,
                                logic signed [SAMPLE_WIDTH-1:0] sb);
            longint       ea;
            longint       eb;
            tick_result_t r;
            ea = longint'(ref_speed) - longint'(sa);
            eb = longint'(ref_speed) - longint'(sb);
            r.error_a = ea[ERR_WIDTH-1:0];
            r.error_b = eb[ERR_WIDTH-1:0];
            r.drive_a = '0;
            r.drive_b = '0;
            if (en) begin
                r.drive_a  = wheel_drive(ea, g_now_a, g_prev_a, held_err_a, held_drv_a);
                r.drive_b  = wheel_drive(eb, g_now_b, g_prev_b, held_err_b, held_drv_b);
                held_err_a = r.error_a;
                held_err_b = r.error_b;
                held_drv_a = r.drive_a;
                held_drv_b = r.drive_b;
            end else begin
                held_err_a = '0;
                held_err_b = '0;
                held_drv_a = '0;
                held_drv_b = '0;
            end
            queued_ticks.push_back(r);
        endfunction

        function void compare_field(string label, longint want, longint seen);
            if (want != seen) begin
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, label, want, seen);
                mismatches++;
            end
        endfunction

        function void check_tick(logic [OUT_DATA_WIDTH-1:0] data);
            tick_result_t want;
            tick_result_t seen;
            seen = data[OUT_FIELDS_WIDTH-1:0];
            if (queued_ticks.size() == 0) begin
                $display("%0t: unexpected result beat, expected none, actual %h", $time, data);
                mismatches++;
                return;
            end
            want = queued_ticks.pop_front();
            compare_field("drive_a", $signed(want.drive_a), $signed(seen.drive_a));
            compare_field("drive_b", $signed(want.drive_b), $signed(seen.drive_b));
            compare_field("error_a", $signed(want.error_a), $signed(seen.error_a));
            compare_field("error_b", $signed(want.error_b), $signed(seen.error_b));
            compare_field("fill", 0, longint'(data[OUT_DATA_WIDTH-1:OUT_FIELDS_WIDTH]));
        endfunction
    endclass

    logic                       aclk        = 1'b0;
    logic                       aresetn     = 1'b0;
    logic                       cfg_wr_en   = 1'b0;
    logic [CFG_INDEX_WIDTH-1:0] cfg_index   = '0;
    logic [CFG_DATA_WIDTH-1:0]  cfg_wr_data = '0;
    logic                       s_tvalid    = 1'b0;
    logic                       s_tready;
    logic [IN_DATA_WIDTH-1:0]   s_tdata     = '0;
    logic                       m_tvalid;
    logic                       m_tready    = 1'b0;
    logic [OUT_DATA_WIDTH-1:0]  m_tdata;

    logic                       idling_on   = 1'b1;
    int unsigned                cycle_count = 0;
    drive_scoreboard            sb;

    dual_incremental_pi_speed_control u_top (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    always @(posedge aclk) begin
        m_tready <= !(idling_on && $urandom_range(99) < 21);
    end

    always @(negedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_tick(m_tdata);
    end

    task automatic send_beat(bit en, logic signed [SAMPLE_WIDTH-1:0] sa,
                             logic signed [SAMPLE_WIDTH-1:0] sb_speed);
        while (idling_on && $urandom_range(99) < 21) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= IN_DATA_WIDTH'({sb_speed, sa, en});
        do @(negedge aclk); while (!s_tready);
        sb.take_tick(en, sa, sb_speed);
        @(posedge aclk);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.queued_ticks.size() != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic cfg_write(logic [CFG_INDEX_WIDTH-1:0] idx, logic [CFG_DATA_WIDTH-1:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= idx;
        cfg_wr_data <= value;
        sb.write_reg(idx, value);
        @(posedge aclk);
    endtask

    task automatic apply_config(logic [CFG_DATA_WIDTH-1:0] ref_v, logic [CFG_DATA_WIDTH-1:0] lim_v,
                                logic [CFG_DATA_WIDTH-1:0] gna, logic [CFG_DATA_WIDTH-1:0] gpa,
                                logic [CFG_DATA_WIDTH-1:0] gnb, logic [CFG_DATA_WIDTH-1:0] gpb);
        drain();
        cfg_write(REG_SPARE_LO, CFG_DATA_WIDTH'($urandom));
        cfg_write(REG_SPARE_HI, CFG_DATA_WIDTH'($urandom));
        cfg_write(REG_REFERENCE_SPEED, ref_v);
        cfg_write(REG_VOLTAGE_LIMIT, lim_v);
        cfg_write(REG_GAIN_NOW_A, gna);
        cfg_write(REG_GAIN_PREV_A, gpa);
        cfg_write(REG_GAIN_NOW_B, gnb);
        cfg_write(REG_GAIN_PREV_B, gpb);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    function automatic logic signed [SAMPLE_WIDTH-1:0] pick_speed(
            logic signed [SAMPLE_WIDTH-1:0] target);
        int unsigned k;
        longint      v;
        k = $urandom_range(99);
        if (k < 60) begin
            v = longint'(target) + longint'($urandom_range(1024)) - 512;
            if (v > 32767)
                v = 32767;
            if (v < -32768)
                v = -32768;
        end else if (k < 90) begin
            v = longint'($urandom);
        end else begin
            v = $urandom_range(1) ? 32767 : -32768;
        end
        return v[SAMPLE_WIDTH-1:0];
    endfunction

    function automatic logic [CFG_DATA_WIDTH-1:0] pick_ref();
        case ($urandom_range(9))
            0: return 16'h8000;
            1: return 16'h7FFF;
            default: return CFG_DATA_WIDTH'(int'($urandom_range(8192)) - 4096);
        endcase
    endfunction

    function automatic logic [CFG_DATA_WIDTH-1:0] pick_limit();
        case ($urandom_range(9))
            0: return 16'h0000;
            1: return 16'hFFFF;
            2: return CFG_DATA_WIDTH'($urandom);
            default: return CFG_DATA_WIDTH'($urandom_range(6000, 1024));
        endcase
    endfunction

    function automatic logic [CFG_DATA_WIDTH-1:0] pick_gain(logic signed [GAIN_WIDTH-1:0] nominal,
                                                            logic signed [GAIN_WIDTH-1:0] low);
        case ($urandom_range(3))
            0: return nominal;
            1: return low;
            default: return CFG_DATA_WIDTH'($urandom);
        endcase
    endfunction

    initial begin
        sb = new();
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_beat(1'b0, 16'sh8000, 16'sh7FFF);
        send_beat(1'b1, 16'sd2560, 16'sd2560);
        send_beat(1'b1, 16'sd0, 16'sd0);
        send_beat(1'b1, 16'sh8000, 16'sh7FFF);
        send_beat(1'b1, 16'sh8000, 16'sh7FFF);
        send_beat(1'b1, 16'sh7FFF, 16'sh8000);
        send_beat(1'b0, 16'sd1234, -16'sd1234);
        send_beat(1'b1, 16'sd0, 16'sd0);

        apply_config(16'h8000, 16'h0000, 16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF);
        send_beat(1'b0, 16'sd0, 16'sd0);
        send_beat(1'b1, 16'sh7FFF, 16'sh8000);
        send_beat(1'b1, 16'sh8000, 16'sh7FFF);

        apply_config(16'h7FFF, 16'hFFFF, 16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF);
        send_beat(1'b0, 16'sd0, 16'sd0);
        send_beat(1'b1, 16'sh8000, 16'sh8000);
        send_beat(1'b1, 16'sh7FFF, 16'sh7FFF);
        send_beat(1'b1, 16'sh8000, 16'sh7FFF);
        send_beat(1'b1, 16'sd0, 16'sd0);
        send_beat(1'b1, 16'sh8000, 16'sh8000);

        for (int p = 0; p < 6; p++) begin
            drain();
            idling_on <= (p != 2);
            apply_config(pick_ref(), pick_limit(),
                         pick_gain(RESET_GAIN_NOW_A, LOW_GAIN_NOW_A),
                         pick_gain(RESET_GAIN_PREV_A, LOW_GAIN_PREV_A),
                         pick_gain(RESET_GAIN_NOW_B, LOW_GAIN_NOW_B),
                         pick_gain(RESET_GAIN_PREV_B, LOW_GAIN_PREV_B));
            send_beat(1'b0, pick_speed(sb.ref_speed), pick_speed(sb.ref_speed));
            repeat (200)
                send_beat($urandom_range(99) < 92, pick_speed(sb.ref_speed),
                          pick_speed(sb.ref_speed));
        end

        drain();
        repeat (8) @(posedge aclk);
        if (sb.mismatches == 0 && sb.queued_ticks.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

`default_nettype wire
